// ===== rtl/vertex_triple_dedup_indexer_unit_defines.svh =====
// Assertion macros shared by the dedup indexer checker.
// Included by the checker file only.
`ifndef VERTEX_TRIPLE_DEDUP_INDEXER_UNIT_DEFINES_SVH
`define VERTEX_TRIPLE_DEDUP_INDEXER_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define VTD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VTD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vtd_pkg.sv =====
// Package for the vertex triple dedup indexer.
// Holds shared constants and the controller/datapath command and status types.
`default_nettype none
package vtd_pkg;
  localparam int TableEntriesDef = 1024;
  localparam int IndexBitsDef    = 20;
  localparam int FieldBits       = 20;
  localparam int FinalBits       = 10;

  // register indexes of the configuration port
  localparam logic CfgTexcoords = 1'b0;
  localparam logic CfgNormals   = 1'b1;

  typedef struct packed {
    logic load;      // capture input transaction, clear scan pointer
    logic clr_count; // start of mesh
    logic scan;      // issue read at scan pointer, advance
    logic insert;    // write triple at entry count
    logic set_res;   // build result (hit or miss)
  } vtd_cmd_t;

  typedef struct packed {
    logic scan_done; // all valid entries issued
    logic rd_pend;   // a read is in flight this cycle
    logic hit;       // registered compare matched
    logic full;      // table full
  } vtd_sts_t;
endpackage
`default_nettype wire

// ===== rtl/vtd_datapath.sv =====
// Datapath: triple table memory, linear scan compare, entry count, result regs.
// Depends on vtd_pkg.
`default_nettype none
module vtd_datapath #(
  parameter int TableEntries = vtd_pkg::TableEntriesDef,
  parameter int IndexBits    = vtd_pkg::IndexBitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire vtd_pkg::vtd_cmd_t                  cmd_i,
  output vtd_pkg::vtd_sts_t                       sts_o,
  input  wire logic                               use_tex_i,
  input  wire logic                               use_nrm_i,
  input  wire logic [vtd_pkg::FieldBits-1:0]      position_index_i,
  input  wire logic [vtd_pkg::FieldBits-1:0]      texcoord_index_i,
  input  wire logic [vtd_pkg::FieldBits-1:0]      normal_index_i,
  output logic [vtd_pkg::FinalBits-1:0]           final_index_o,
  output logic                                    is_new_o,
  output logic                                    overflow_o,
  output logic [vtd_pkg::FieldBits-1:0]           new_position_o,
  output logic [vtd_pkg::FieldBits-1:0]           new_texcoord_o,
  output logic [vtd_pkg::FieldBits-1:0]           new_normal_o
);
  import vtd_pkg::*;

  localparam int AddrBits  = $clog2(TableEntries);
  localparam int CntBits   = AddrBits + 1;
  localparam int EntryBits = 3 * IndexBits;

  logic [EntryBits-1:0] mem_q [TableEntries];
  logic [EntryBits-1:0] rd_q;
  logic [EntryBits-1:0] key_q;
  logic [CntBits-1:0]   cnt_q;
  logic [CntBits-1:0]   ptr_q;
  logic [AddrBits-1:0]  rd_addr_q;
  logic                 rd_vld_q;
  logic                 hit_q;
  logic [AddrBits-1:0]  hit_idx_q;
  logic [CntBits-1:0]   cnt_eff;
  logic [EntryBits-1:0] key_d;

  // masked key of the incoming transaction
  always_comb begin
    key_d = {position_index_i[IndexBits-1:0],
             use_tex_i ? texcoord_index_i[IndexBits-1:0] : {IndexBits{1'b0}},
             use_nrm_i ? normal_index_i[IndexBits-1:0]   : {IndexBits{1'b0}}};
  end

  assign cnt_eff = cnt_q;

  // table memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      mem_q[cnt_q[AddrBits-1:0]] <= key_q;
    end
    rd_q <= mem_q[ptr_q[AddrBits-1:0]];
  end

  // key, scan pointer, compare and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      rd_addr_q <= '0;
      hit_idx_q <= '0;
      key_q     <= '0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.load) begin
        key_q <= key_d;
        ptr_q <= '0;
        hit_q <= 1'b0;
        if (cmd_i.clr_count) begin
          cnt_q <= '0;
        end
      end else begin
        if (cmd_i.scan) begin
          rd_addr_q <= ptr_q[AddrBits-1:0];
          ptr_q     <= ptr_q + 1'b1;
        end
        if (rd_vld_q && !hit_q && rd_q == key_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= rd_addr_q;
        end
        if (cmd_i.insert) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign sts_o.scan_done = (ptr_q >= cnt_eff);
  assign sts_o.rd_pend   = rd_vld_q;
  assign sts_o.hit       = hit_q;
  assign sts_o.full      = (cnt_q == CntBits'(TableEntries));

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_res) begin
      is_new_o       <= 1'b0;
      overflow_o     <= 1'b0;
      final_index_o  <= '0;
      new_position_o <= '0;
      new_texcoord_o <= '0;
      new_normal_o   <= '0;
      if (hit_q) begin
        final_index_o <= FinalBits'({{(32-AddrBits){1'b0}}, hit_idx_q});
      end else if (cnt_q == CntBits'(TableEntries)) begin
        overflow_o <= 1'b1;
      end else begin
        is_new_o       <= 1'b1;
        final_index_o  <= FinalBits'({{(32-CntBits){1'b0}}, cnt_q});
        new_position_o <= FieldBits'(key_q[3*IndexBits-1:2*IndexBits]);
        new_texcoord_o <= FieldBits'(key_q[2*IndexBits-1:IndexBits]);
        new_normal_o   <= FieldBits'(key_q[IndexBits-1:0]);
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/vtd_ctrl.sv =====
// Controller FSM: handshake, scan sequencing, insert and result hold.
// Depends on vtd_pkg.
`default_nettype none
module vtd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              start_of_mesh_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output vtd_pkg::vtd_cmd_t      cmd_o,
  input  wire vtd_pkg::vtd_sts_t sts_i
);
  import vtd_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StOut
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  // a new transaction enters once the result slot is free or leaving
  assign in_stall_o  = !(state_q == StIdle && (!out_valid_q || !out_stall_i));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.clr_count = accept && start_of_mesh_i;
    cmd_o.scan      = (state_q == StScan) && !sts_i.scan_done && !sts_i.hit;
    cmd_o.insert    = (state_q == StDrain) && !sts_i.rd_pend && !sts_i.hit && !sts_i.full;
    cmd_o.set_res   = (state_q == StDrain) && !sts_i.rd_pend;
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StScan;
          end
        end
        StScan: begin
          if (sts_i.scan_done || sts_i.hit) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (!sts_i.rd_pend) begin
            state_q     <= StIdle;
            out_valid_q <= 1'b1;
          end
        end
        StOut: begin
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/vertex_triple_dedup_indexer_unit.sv =====
// Vertex triple dedup indexer: linear scan over a triple table in block RAM.
// A new triple is compared against every entry stored in the mesh so far; for a known
// triple the scan stops once its slot matches. One transaction at a time.
// Throughput is set by the single read port of the table, one entry per cycle.
// Reset: asynchronous active low; clears entry count, config and control;
// table contents are undefined until written.
`default_nettype none
module vertex_triple_dedup_indexer_unit #(
  parameter int TableEntries = vtd_pkg::TableEntriesDef,
  parameter int IndexBits    = vtd_pkg::IndexBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic                          cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          start_of_mesh_i,
  input  wire logic [vtd_pkg::FieldBits-1:0] position_index_i,
  input  wire logic [vtd_pkg::FieldBits-1:0] texcoord_index_i,
  input  wire logic [vtd_pkg::FieldBits-1:0] normal_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [vtd_pkg::FinalBits-1:0]      final_index_o,
  output logic                               is_new_o,
  output logic                               overflow_o,
  output logic [vtd_pkg::FieldBits-1:0]      new_position_o,
  output logic [vtd_pkg::FieldBits-1:0]      new_texcoord_o,
  output logic [vtd_pkg::FieldBits-1:0]      new_normal_o
);
  import vtd_pkg::*;

  logic      use_tex_q;
  logic      use_nrm_q;
  vtd_cmd_t  cmd;
  vtd_sts_t  sts;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_tex_q <= 1'b0;
      use_nrm_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgTexcoords) begin
        use_tex_q <= cfg_data_i;
      end
      if (cfg_idx_i == CfgNormals) begin
        use_nrm_q <= cfg_data_i;
      end
    end
  end

  vtd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .start_of_mesh_i,
    .out_valid_o, .out_stall_i, .cmd_o(cmd), .sts_i(sts)
  );

  vtd_datapath #(.TableEntries(TableEntries), .IndexBits(IndexBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .use_tex_i(use_tex_q), .use_nrm_i(use_nrm_q),
    .position_index_i, .texcoord_index_i, .normal_index_i,
    .final_index_o, .is_new_o, .overflow_o,
    .new_position_o, .new_texcoord_o, .new_normal_o
  );
endmodule
`default_nettype wire

// ===== rtl/vtd_checker.sv =====
// Port-level checker for the dedup indexer, bound to the top level.
// Depends on vertex_triple_dedup_indexer_unit_defines.svh.
`default_nettype none
`include "vertex_triple_dedup_indexer_unit_defines.svh"
module vtd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       is_new_o,
  input wire logic       overflow_o,
  input wire logic [9:0] final_index_o
);
  `VTD_ASSERT_IMP(a_new_ovf_excl, clk_i, rst_ni, out_valid_o, !(is_new_o && overflow_o), "new and overflow together")
  `VTD_ASSERT_IMP(a_ovf_zero, clk_i, rst_ni, out_valid_o && overflow_o, final_index_o == 10'd0, "overflow index not zero")
  `VTD_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "accepted while busy")
  `VTD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(final_index_o), "result dropped")
endmodule

bind vertex_triple_dedup_indexer_unit vtd_checker u_vtd_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .is_new_o, .overflow_o, .final_index_o
);
`default_nettype wire
